/* sv/mwo_pkg.sv */
// Shared types and constants for the mecanum wheel odometry block.
// Used by mwo_controller, mwo_datapath and mecanum_wheel_odometry.
`default_nettype none
package mwo_pkg;

  localparam int DW = 128;               // width of products, quotient, remainder
  localparam int MB_W = 64;              // multiplier operand width
  localparam int CNT_W = $clog2(DW);

  localparam logic [MB_W-1:0] NS_PER_S   = 64'd1000000000;
  localparam logic [MB_W-1:0] TWO_PI_Q32 = 64'd26986075409;

  localparam logic [7:0] REG_COUNTS_PER_REV = 8'd0;
  localparam logic [7:0] REG_GEAR_RATIO     = 8'd1;
  localparam logic [7:0] REG_WHEEL_RADIUS   = 8'd2;
  localparam logic [7:0] REG_HALF_TRACK     = 8'd3;

  localparam logic [15:0] RST_COUNTS_PER_REV = 16'd1024;
  localparam logic [7:0]  RST_GEAR_RATIO     = 8'd5;
  localparam logic [15:0] RST_WHEEL_RADIUS   = 16'd4915;
  localparam logic [23:0] RST_HALF_TRACK     = 24'd24183;

  typedef enum logic [3:0] {
    S_IDLE, S_DEN_LIN, S_DEN_YAW, S_NUM_R, S_NUM_NS, S_NUM_PI, S_DIV, S_ROUND, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_DT, MS_HALF_TRACK, MS_MAG, MS_NS, MS_PI
  } mul_src_t;

  typedef struct packed {
    logic       capture;
    logic       ld_mul;
    mul_src_t   src;
    logic [1:0] mag_sel;
    logic       mul_step;
    logic       save_lin;
    logic       save_yaw;
    logic       div_ld;
    logic       div_step;
    logic       round;
    logic [1:0] vel_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic backward;
    logic mul_done;
  } status_t;

endpackage
`default_nettype wire

/* sv/mwo_controller.sv */
// Sequencer for the odometry datapath: handshakes, multiply/divide steps.
// Depends on mwo_pkg.
`default_nettype none
module mwo_controller (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire mwo_pkg::status_t status,
  output mwo_pkg::cmd_t        cmd
);
  import mwo_pkg::*;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DW - 1);
  localparam logic [1:0] VEL_YAW = 2'd2;

  state_t state, state_next;
  logic [1:0] vel;
  logic [CNT_W-1:0] div_cnt;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.first) state_next = S_IDLE;
          else if (status.backward) state_next = S_DONE;
          else state_next = S_DEN_LIN;
        end
      end
      S_DEN_LIN: if (status.mul_done) state_next = S_DEN_YAW;
      S_DEN_YAW: if (status.mul_done) state_next = S_NUM_R;
      S_NUM_R:   if (status.mul_done) state_next = S_NUM_NS;
      S_NUM_NS:  if (status.mul_done) state_next = S_NUM_PI;
      S_NUM_PI:  if (status.mul_done) state_next = S_DIV;
      S_DIV:     if (div_cnt == DIV_LAST) state_next = S_ROUND;
      S_ROUND:   state_next = (vel == VEL_YAW) ? S_DONE : S_NUM_R;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.src = MS_DT;
    cmd.vel_sel = vel;
    cmd.mag_sel = vel;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!status.first && !status.backward) begin
            cmd.ld_mul = 1'b1;
            cmd.src = MS_DT;
          end
        end
      end
      S_DEN_LIN: begin
        if (status.mul_done) begin
          cmd.save_lin = 1'b1;
          cmd.ld_mul = 1'b1;
          cmd.src = MS_HALF_TRACK;
        end else cmd.mul_step = 1'b1;
      end
      S_DEN_YAW: begin
        if (status.mul_done) begin
          cmd.save_yaw = 1'b1;
          cmd.ld_mul = 1'b1;
          cmd.src = MS_MAG;
          cmd.mag_sel = 2'd0;
        end else cmd.mul_step = 1'b1;
      end
      S_NUM_R: begin
        if (status.mul_done) begin
          cmd.ld_mul = 1'b1;
          cmd.src = MS_NS;
        end else cmd.mul_step = 1'b1;
      end
      S_NUM_NS: begin
        if (status.mul_done) begin
          cmd.ld_mul = 1'b1;
          cmd.src = MS_PI;
        end else cmd.mul_step = 1'b1;
      end
      S_NUM_PI: begin
        if (status.mul_done) cmd.div_ld = 1'b1;
        else cmd.mul_step = 1'b1;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_ROUND: begin
        cmd.round = 1'b1;
        if (vel != VEL_YAW) begin
          cmd.ld_mul = 1'b1;
          cmd.src = MS_MAG;
          cmd.mag_sel = vel + 2'd1;
        end
      end
      S_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vel <= 2'd0;
      div_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) vel <= 2'd0;
      else if (cmd.round) vel <= vel + 2'd1;
      if (cmd.div_ld) div_cnt <= '0;
      else if (cmd.div_step) div_cnt <= div_cnt + 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* sv/mwo_datapath.sv */
// Odometry datapath: history, wheel sums, shift-add multiplier,
// restoring divider, rounding/saturation and the output register. Uses mwo_pkg.
`default_nettype none
module mwo_datapath #(
  parameter int TICK_BITS = 32,
  parameter int VEL_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [62:0]        timestamp_ns,
  input  wire logic signed [31:0] ticks_front_left,
  input  wire logic signed [31:0] ticks_front_right,
  input  wire logic signed [31:0] ticks_rear_left,
  input  wire logic signed [31:0] ticks_rear_right,
  input  wire mwo_pkg::cmd_t      cmd,
  output mwo_pkg::status_t        status,
  output logic signed [31:0]      vel_forward_q16,
  output logic signed [31:0]      vel_lateral_q16,
  output logic signed [31:0]      yaw_rate_q16,
  output logic [62:0]             stamp_out,
  output logic                    zero_interval,
  output logic                    saturated
);
  import mwo_pkg::*;

  localparam int SUM_W = TICK_BITS + 3;
  localparam int FWD_SH = 50 - VEL_FRAC_BITS;
  localparam int YAW_SH = 34 - VEL_FRAC_BITS;
  localparam logic [DW-1:0] HALF_F = DW'(1) << (FWD_SH - 1);
  localparam logic [DW-1:0] HALF_Y = DW'(1) << (YAW_SH - 1);
  localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG = 32'h8000_0000;

  // configuration
  logic [15:0] counts_per_rev, wheel_radius;
  logic [7:0]  gear_ratio;
  logic [23:0] half_track;
  logic [15:0] n_eff;
  logic [7:0]  t_eff;
  logic [23:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= RST_COUNTS_PER_REV;
      gear_ratio <= RST_GEAR_RATIO;
      wheel_radius <= RST_WHEEL_RADIUS;
      half_track <= RST_HALF_TRACK;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COUNTS_PER_REV: counts_per_rev <= cfg_data[15:0];
        REG_GEAR_RATIO:     gear_ratio <= cfg_data[7:0];
        REG_WHEEL_RADIUS:   wheel_radius <= cfg_data[15:0];
        REG_HALF_TRACK:     half_track <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // zero counts as one
  assign n_eff = (counts_per_rev == '0) ? 16'd1 : counts_per_rev;
  assign t_eff = (gear_ratio == '0) ? 8'd1 : gear_ratio;
  assign h_eff = (half_track == '0) ? 24'd1 : half_track;

  // history and wheel sums
  logic [62:0] prev_ts, cur_stamp;
  logic [31:0] prev_ticks [4];
  logic [31:0] cur [4];
  logic have_prev;
  logic [TICK_BITS-1:0] dif [4];
  logic signed [SUM_W-1:0] d [4];
  logic signed [SUM_W-1:0] s_new [3];
  logic [SUM_W-1:0] mag [3];
  logic [2:0] neg;
  logic [62:0] dt;

  assign cur[0] = ticks_front_left;
  assign cur[1] = ticks_front_right;
  assign cur[2] = ticks_rear_left;
  assign cur[3] = ticks_rear_right;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dif[i] = cur[i][TICK_BITS-1:0] - prev_ticks[i][TICK_BITS-1:0];
      d[i] = {{3{dif[i][TICK_BITS-1]}}, dif[i]};
    end
    s_new[0] = d[0] + d[1] + d[2] + d[3];
    s_new[1] = -d[0] + d[1] + d[2] - d[3];
    s_new[2] = -d[0] + d[1] - d[2] + d[3];
  end

  assign dt = timestamp_ns - prev_ts;
  assign status.first = !have_prev;
  assign status.backward = timestamp_ns <= prev_ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_ts <= '0;
      for (int i = 0; i < 4; i++) prev_ticks[i] <= '0;
    end else if (cmd.capture) begin
      have_prev <= 1'b1;
      prev_ts <= timestamp_ns;
      for (int i = 0; i < 4; i++) prev_ticks[i] <= cur[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_stamp <= timestamp_ns;
      for (int k = 0; k < 3; k++) begin
        neg[k] <= s_new[k][SUM_W-1];
        mag[k] <= s_new[k][SUM_W-1] ? SUM_W'(-s_new[k]) : SUM_W'(s_new[k]);
      end
    end
  end

  // shift-add multiplier: prod = ma * mb, one multiplier bit a cycle
  logic [DW-1:0] ma, prod, den_lin, den_yaw;
  logic [MB_W-1:0] mb;
  logic [MB_W-1:0] nt;

  assign nt = MB_W'(n_eff) * MB_W'(t_eff);
  assign status.mul_done = (mb == '0);

  always_ff @(posedge clk) begin
    if (cmd.ld_mul) begin
      prod <= '0;
      case (cmd.src)
        MS_DT: begin
          ma <= DW'(dt);
          mb <= nt;
        end
        MS_HALF_TRACK: begin
          ma <= prod;
          mb <= MB_W'(h_eff);
        end
        MS_MAG: begin
          ma <= DW'(mag[cmd.mag_sel]);
          mb <= MB_W'(wheel_radius);
        end
        MS_NS: begin
          ma <= prod;
          mb <= NS_PER_S;
        end
        MS_PI: begin
          ma <= prod;
          mb <= TWO_PI_Q32;
        end
        default: begin
          ma <= '0;
          mb <= '0;
        end
      endcase
    end else if (cmd.mul_step) begin
      if (mb[0]) prod <= prod + ma;
      ma <= ma << 1;
      mb <= mb >> 1;
    end
    if (cmd.save_lin) den_lin <= prod;
    if (cmd.save_yaw) den_yaw <= prod;
  end

  // restoring divider, one quotient bit a cycle
  logic [DW-1:0] rem, numsh, quo, rem_sh, den_sel;
  logic fits;

  assign den_sel = (cmd.vel_sel == 2'd2) ? den_yaw : den_lin;
  assign rem_sh = {rem[DW-2:0], numsh[DW-1]};
  assign fits = rem_sh >= den_sel;

  always_ff @(posedge clk) begin
    if (cmd.div_ld) begin
      rem <= '0;
      numsh <= prod;
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= fits ? rem_sh - den_sel : rem_sh;
      numsh <= numsh << 1;
      quo <= {quo[DW-2:0], fits};
    end
  end

  // round to nearest, sign, clamp
  logic [DW-1:0] rnd, shv;
  logic [31:0] lim, mag32, val;
  logic over, is_yaw, vneg;
  logic [31:0] vel [3];
  logic sat_acc, zero_flag;

  always_comb begin
    is_yaw = (cmd.vel_sel == 2'd2);
    vneg = neg[cmd.vel_sel];
    rnd = quo + (is_yaw ? HALF_Y : HALF_F);
    shv = is_yaw ? (rnd >> YAW_SH) : (rnd >> FWD_SH);
    lim = vneg ? LIM_NEG : LIM_POS;
    over = (|shv[DW-1:32]) || (shv[31:0] > lim);
    mag32 = over ? lim : shv[31:0];
    val = vneg ? -mag32 : mag32;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int k = 0; k < 3; k++) vel[k] <= '0;
      sat_acc <= 1'b0;
      zero_flag <= status.backward;
    end else if (cmd.round) begin
      vel[cmd.vel_sel] <= val;
      sat_acc <= sat_acc | over;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      vel_forward_q16 <= vel[0];
      vel_lateral_q16 <= vel[1];
      yaw_rate_q16 <= vel[2];
      stamp_out <= cur_stamp;
      zero_interval <= zero_flag;
      saturated <= sat_acc;
    end
  end

endmodule
`default_nettype wire

/* sv/mecanum_wheel_odometry.sv */
// Top level of the mecanum wheel odometry block.
// Instantiates mwo_controller and mwo_datapath; uses mwo_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready): one transaction is one sample, a
//    timestamp and four absolute encoder counts (FL, FR, RL, RR).
//  - Output channel (out_valid/out_ready): one transaction per sample except
//    the first after reset, which only loads the history.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//    write only while the block is idle. Unknown indexes are dropped.
//  - Processing: a sample with a forward interval runs through a serial
//    shift-add multiplier (one multiplier bit a cycle) and a restoring
//    divider (once for each of the three velocities); the wait for
//    out_valid is set by the operand bit lengths and mostly by the divider.
//    A zero or backward interval skips both and goes straight to the done
//    state, which loads the output register once it is free; after the first
//    sample in_ready is back the next cycle.
//  - One sample at a time; in_ready is high only while idle. A finished
//    result sits in the output register, so the next sample is accepted
//    while the receiver stalls; its result waits until that one is taken.
//  - Reset (rst, synchronous): restores default config, clears history and
//    drops any pending result.
`default_nettype none
module mecanum_wheel_odometry #(
  parameter int TICK_BITS = 32,
  parameter int VEL_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [62:0]        timestamp_ns,
  input  wire logic signed [31:0] ticks_front_left,
  input  wire logic signed [31:0] ticks_front_right,
  input  wire logic signed [31:0] ticks_rear_left,
  input  wire logic signed [31:0] ticks_rear_right,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      vel_forward_q16,
  output logic signed [31:0]      vel_lateral_q16,
  output logic signed [31:0]      yaw_rate_q16,
  output logic [62:0]             stamp_out,
  output logic                    zero_interval,
  output logic                    saturated
);
  import mwo_pkg::*;

  cmd_t cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  mwo_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mwo_datapath #(
    .TICK_BITS     (TICK_BITS),
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .timestamp_ns      (timestamp_ns),
    .ticks_front_left  (ticks_front_left),
    .ticks_front_right (ticks_front_right),
    .ticks_rear_left   (ticks_rear_left),
    .ticks_rear_right  (ticks_rear_right),
    .cmd               (cmd),
    .status            (status),
    .vel_forward_q16   (vel_forward_q16),
    .vel_lateral_q16   (vel_lateral_q16),
    .yaw_rate_q16      (yaw_rate_q16),
    .stamp_out         (stamp_out),
    .zero_interval     (zero_interval),
    .saturated         (saturated)
  );

`ifndef SYNTH
  // zero interval forces zero velocities and no clamp
  a_zero_iv: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_interval |->
      vel_forward_q16 == '0 && vel_lateral_q16 == '0 && yaw_rate_q16 == '0 && !saturated)
    else $error("zero interval with nonzero velocity");

  // a clamp shows up as a rail value on some velocity
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      vel_forward_q16 == 32'sh7FFF_FFFF || vel_forward_q16 == 32'sh8000_0000 ||
      vel_lateral_q16 == 32'sh7FFF_FFFF || vel_lateral_q16 == 32'sh8000_0000 ||
      yaw_rate_q16 == 32'sh7FFF_FFFF || yaw_rate_q16 == 32'sh8000_0000)
    else $error("saturated without rail value");

  // the output register is never overwritten while a result waits
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("result overwritten");
`endif

endmodule
`default_nettype wire

/* tb/sv/mecanum_wheel_odometry_test.sv */
// Self-checking testbench for mecanum_wheel_odometry: random and directed samples,
// velocities predicted with wide integer math. Depends on mwo_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module mecanum_wheel_odometry_test;
  import mwo_pkg::*;

  localparam logic [7:0] REG_UNUSED = 8'd9;   // not a register; must be dropped
  localparam int SETTLE = 900;                // cycles covering the longest sample
  localparam logic [62:0] STAMP_MAX = {63{1'b1}};

  // One result transaction as seen on the output ports
  typedef struct packed {
    logic signed [31:0] fwd;
    logic signed [31:0] lat;
    logic signed [31:0] yaw;
    logic [62:0]        stamp;
    logic               zero_dt;
    logic               clamp;
  } velocity_t;

  // Predicts body velocities and holds the ones not yet seen at the output.
  class odometry_scoreboard;
    logic [15:0] counts_per_rev;
    logic [7:0]  gear_ratio;
    logic [15:0] wheel_radius;
    logic [23:0] half_track;
    logic [62:0] last_stamp;
    logic [31:0] last_ticks [4];
    bit          primed;
    velocity_t   pending_vel [$];
    int          mismatches;
    int          checked;
    int          clamped_seen;
    int          zero_dt_seen;

    function void reset_state();
      counts_per_rev = RST_COUNTS_PER_REV;
      gear_ratio = RST_GEAR_RATIO;
      wheel_radius = RST_WHEEL_RADIUS;
      half_track = RST_HALF_TRACK;
      last_stamp = '0;
      foreach (last_ticks[i]) last_ticks[i] = '0;
      primed = 0;
      pending_vel.delete();
      mismatches = 0;
      checked = 0;
      clamped_seen = 0;
      zero_dt_seen = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        REG_COUNTS_PER_REV: counts_per_rev = data[15:0];
        REG_GEAR_RATIO:     gear_ratio = data[7:0];
        REG_WHEEL_RADIUS:   wheel_radius = data[15:0];
        REG_HALF_TRACK:     half_track = data[23:0];
        default: ;
      endcase
    endfunction

    // |sum| * R * 1e9 * 2pi / base, rounded half away, then signed and clamped
    function logic [31:0] scaled_rate(longint sum, logic [255:0] base, int shift,
                                      inout bit clamp);
      logic [255:0] q;
      logic [255:0] lim;
      bit neg;
      neg = sum < 0;
      q = neg ? 256'(-sum) : 256'(sum);
      lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
      q = q * wheel_radius;
      q = q * NS_PER_S;
      q = q * TWO_PI_Q32;
      q = q / base;
      q = q + (256'd1 << (shift - 1));
      q = q >> shift;
      if (q > lim) begin
        q = lim;
        clamp = 1;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_sample(logic [62:0] stamp, logic [31:0] ticks [4]);
      longint d [4];
      logic [31:0] diff;
      logic [255:0] nt, base;
      velocity_t v;
      bit clamp;
      foreach (d[i]) begin
        diff = ticks[i] - last_ticks[i];
        d[i] = longint'($signed(diff));
        last_ticks[i] = ticks[i];
      end
      v.stamp = stamp;
      v.fwd = '0; v.lat = '0; v.yaw = '0;
      v.zero_dt = 0; v.clamp = 0;
      clamp = 0;
      if (primed) begin
        if (stamp <= last_stamp) begin
          v.zero_dt = 1;
        end else begin
          nt = 256'(counts_per_rev == 0 ? 16'd1 : counts_per_rev);
          nt = nt * (gear_ratio == 0 ? 8'd1 : gear_ratio);
          base = nt * (stamp - last_stamp);
          v.fwd = scaled_rate(d[0] + d[1] + d[2] + d[3], base, 50 - 16, clamp);
          v.lat = scaled_rate(-d[0] + d[1] + d[2] - d[3], base, 50 - 16, clamp);
          base = base * (half_track == 0 ? 24'd1 : half_track);
          v.yaw = scaled_rate(-d[0] + d[1] - d[2] + d[3], base, 34 - 16, clamp);
          v.clamp = clamp;
        end
        pending_vel.push_back(v);
      end
      last_stamp = stamp;
      primed = 1;
    endfunction

    function void check_result(velocity_t got);
      velocity_t want;
      checked++;
      if (got.clamp) clamped_seen++;
      if (got.zero_dt) zero_dt_seen++;
      if (pending_vel.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with none expected, stamp %0d", got.stamp);
        return;
      end
      want = pending_vel.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: stamp %0d exp fwd %0d lat %0d yaw %0d st %0d z %0b s %0b, got fwd %0d lat %0d yaw %0d st %0d z %0b s %0b",
                   want.stamp, want.fwd, want.lat, want.yaw, want.stamp, want.zero_dt, want.clamp,
                   got.fwd, got.lat, got.yaw, got.stamp, got.zero_dt, got.clamp);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [62:0] timestamp_ns = '0;
  logic signed [31:0] ticks_front_left = '0, ticks_front_right = '0;
  logic signed [31:0] ticks_rear_left = '0, ticks_rear_right = '0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] vel_forward_q16, vel_lateral_q16, yaw_rate_q16;
  logic [62:0] stamp_out;
  logic zero_interval, saturated;

  odometry_scoreboard sb = new();
  bit hold_req = 0;           // asks the receiver for one long stall
  int samples_sent = 0;
  logic [62:0] cur_stamp = '0;
  logic [31:0] cur_ticks [4] = '{default: '0};
  int burst_left = 0;

  mecanum_wheel_odometry DUT (.*);

  initial forever #4 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

  // Output side: check every accepted result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{vel_forward_q16, vel_lateral_q16, yaw_rate_q16, stamp_out,
                        zero_interval, saturated});
  end

  // Receiver: stall pattern changes after a random span; one long hold-off on request
  initial begin
    int mode, span;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(50, 400);
        for (int c = 0; c < span && !hold_req; c++) begin
          case (mode)
            0: out_ready <= 1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= (c % 7) != 0;
            default: out_ready <= $urandom_range(0, 9) == 0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Register write; only called while the block is idle
  task automatic write_cfg(logic [7:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Offer one sample and wait for its transaction; valid is left high
  task automatic push_sample(logic [62:0] stamp, logic [31:0] ticks [4]);
    in_valid <= 1;
    timestamp_ns <= stamp;
    ticks_front_left <= ticks[0];
    ticks_front_right <= ticks[1];
    ticks_rear_left <= ticks[2];
    ticks_rear_right <= ticks[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(stamp, ticks);
    samples_sent++;
    cur_stamp = stamp;
    cur_ticks = ticks;
  endtask

  task automatic direct(logic [62:0] stamp, logic [31:0] fl, logic [31:0] fr,
                        logic [31:0] rl, logic [31:0] rr);
    logic [31:0] t [4];
    t = '{fl, fr, rl, rr};
    push_sample(stamp, t);
  endtask

  // Sender-side idling: bursts of random length, random gaps between them
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every expected result is in, then lets the block settle
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_vel.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_sample();
    logic [62:0] stamp;
    logic [31:0] t [4];
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) stamp = cur_stamp + $urandom_range(100_000, 20_000_000);
    else if (pick < 72) stamp = cur_stamp + 1;
    else if (pick < 80) stamp = cur_stamp;
    else if (pick < 87) stamp = cur_stamp - $urandom_range(1, 1_000_000);
    else if (pick < 94) stamp = {$urandom, $urandom};
    else stamp = cur_stamp + $urandom_range(1, 1000);
    pick = $urandom_range(0, 9);
    foreach (t[i]) begin
      if (pick < 7) t[i] = cur_ticks[i] + $signed($urandom_range(0, 8000)) - 4000;
      else if (pick < 9) t[i] = $urandom;
      else t[i] = cur_ticks[i] + $urandom_range(0, 3) - 1;
    end
    push_sample(stamp, t);
  endtask

  task automatic random_phase(int count, bit squeeze);
    for (int k = 0; k < count; k++) begin
      // midway through, stall the receiver long while samples keep coming
      if (squeeze && k == count / 2) hold_req = 1;
      random_sample();
      sender_gap();
    end
    drain();
  endtask

  initial begin
    sb.reset_state();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: defaults, first sample primes history only
    direct(63'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    direct(63'd1_000_000, 32'd100, 32'd100, 32'd100, 32'd100);      // straight ahead
    direct(63'd2_000_000, 32'd0, 32'd200, 32'd200, 32'd0);          // pure strafe
    direct(63'd3_000_000, -32'd50, 32'd250, -32'd50, 32'd250);      // spin combined with strafe
    direct(63'd3_000_000, 32'd1, 32'd2, 32'd3, 32'd4);              // zero interval
    direct(63'd2_500_000, 32'd5, 32'd5, 32'd5, 32'd5);              // backward interval
    direct(63'd2_500_001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
    direct(63'd2_600_001, 32'h8000_0005, 32'h7FFF_FFF0, 32'd3, 32'hFFFF_FFFE); // wraps
    direct(63'd2_600_002, 32'h0000_0005, 32'hFFFF_FFF0, 32'h8000_0003,
           32'h7FFF_FFFE);                                          // saturating, dt = 1
    direct(63'd2_600_003, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    direct(STAMP_MAX, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001);
    direct(63'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    direct(STAMP_MAX, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC);
    drain();

    // Phase set: defaults with a long receiver hold-off
    random_phase(200, 1);

    // Smallest legal settings, plus a write to a nonexistent register
    write_cfg(REG_COUNTS_PER_REV, 32'd1);
    write_cfg(REG_GEAR_RATIO, 32'd1);
    write_cfg(REG_WHEEL_RADIUS, 32'd1);
    write_cfg(REG_HALF_TRACK, 32'd1);
    write_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    direct(cur_stamp + 1, cur_ticks[0] + 32'h7FFF_FFFF, cur_ticks[1], cur_ticks[2],
           cur_ticks[3]);
    random_phase(200, 0);

    // Largest settings; upper data bits beyond each register are set too
    write_cfg(REG_COUNTS_PER_REV, 32'hFFFF_FFFF);
    write_cfg(REG_GEAR_RATIO, 32'hFFFF_FFFF);
    write_cfg(REG_WHEEL_RADIUS, 32'hFFFF_FFFF);
    write_cfg(REG_HALF_TRACK, 32'hFFFF_FFFF);
    direct(cur_stamp + 1, cur_ticks[0] + 32'h7FFF_FFFF, cur_ticks[1] - 32'h7FFF_FFFF,
           cur_ticks[2], cur_ticks[3]);
    random_phase(200, 0);

    // Two random settings
    for (int p = 0; p < 2; p++) begin
      write_cfg(REG_COUNTS_PER_REV, $urandom_range(1, 65535));
      write_cfg(REG_GEAR_RATIO, $urandom_range(1, 255));
      write_cfg(REG_WHEEL_RADIUS, $urandom_range(1, 65535));
      write_cfg(REG_HALF_TRACK, $urandom_range(1, 16777215));
      random_phase(230, p == 1);
    end

    drain();
    $display("Ran %0d samples, %0d results (%0d zero-interval, %0d clamped) over 5 settings",
             samples_sent, sb.checked, sb.zero_dt_seen, sb.clamped_seen);
    if (sb.mismatches == 0 && sb.pending_vel.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_vel.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
